/* src/gfalu_pkg.sv */
// gfalu_pkg: shared types, constants and codes of the gf(2^m) field alu
// used by gfalu_mul and gf2m_field_alu; depends on nothing
package gfalu_pkg;

  localparam int MAX_DEGREE = 32;
  localparam int ELEM_W     = 32;
  localparam int MOD_W      = ELEM_W + 1;
  localparam int DEG_W      = 6;
  localparam int TOP_W      = $clog2(ELEM_W);
  localparam int EXP_W      = 64;
  localparam int DIGIT_W    = 8;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;

  localparam logic              REG_DEGREE   = 1'b0;
  localparam logic              REG_POLY     = 1'b1;
  localparam logic [DEG_W-1:0]  RESET_DEGREE = 6'd8;
  localparam logic [ELEM_W-1:0] RESET_POLY   = 32'd27;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_POW = 3'd2,
    OP_INV = 3'd3,
    OP_DIV = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NONINV = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ELEM_W-1:0] operand_a;
    logic [ELEM_W-1:0] operand_b;
    logic [EXP_W-1:0]  exponent;
  } gfalu_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result;
    logic [ST_W-1:0]   status;
  } gfalu_out_t;

  // field description shared with the multiplier
  typedef struct packed {
    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] poly;
    logic [TOP_W-1:0]  top_idx;
  } field_t;

endpackage

/* src/gfalu_mul.sv */
// gfalu_mul: digit-serial gf(2^m) multiplier, eight bits of b per cycle
// depends on gfalu_pkg
module gfalu_mul import gfalu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  field_t            field_i,
  input  logic              start_i,
  input  logic [ELEM_W-1:0] a_i,
  input  logic [ELEM_W-1:0] b_i,
  output logic              done_o,
  output logic [ELEM_W-1:0] prod_o
);

  logic              busy_q, done_q;
  logic [ELEM_W-1:0] acc_q, a_q, b_q;
  logic [ELEM_W-1:0] acc_n, a_n, b_n;

  function automatic logic [ELEM_W-1:0] xtime(input logic [ELEM_W-1:0] x,
                                               input field_t f);
    logic [ELEM_W-1:0] r;
    r = (x << 1) & f.mask;
    if (x[f.top_idx]) begin
      r = r ^ f.poly;
    end
    return r;
  endfunction

  always_comb begin
    acc_n = acc_q;
    a_n   = a_q;
    for (int k = 0; k < DIGIT_W; k++) begin
      if (b_q[k]) begin
        acc_n = acc_n ^ a_n;
      end
      a_n = xtime(a_n, field_i);
    end
    b_n = b_q >> DIGIT_W;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= (b_n != '0);
      done_q <= (b_n == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i & field_i.mask;
      b_q   <= b_i & field_i.mask;
    end else if (busy_q) begin
      acc_q <= acc_n;
      a_q   <= a_n;
      b_q   <= b_n;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && busy_q)) else $error("multiplier done while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("multiplier done without work");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier restarted while busy");
  a_prod_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((acc_q & ~field_i.mask) == '0)) else $error("product not reduced");
`endif

endmodule

/* src/gf2m_field_alu.sv */
// gf2m_field_alu: gf(2^m) arithmetic unit top level, sequencer and config
// depends on gfalu_pkg and gfalu_mul
//
// An item is taken when start is high and busy is low; busy stays high until the
// result is issued, and result_valid_o marks it for exactly one cycle with no way
// to hold it off. Every multiply goes through one shared digit-serial multiplier
// that handles eight bits of the second operand per cycle. Add and unused codes
// finish from the idle state without raising busy. Power runs one exponent bit
// per pass of up to two multiplies. Inverse runs binary extended Euclid, each
// step a degree state, a reduce state and one multiply by x^j, over about 2m
// steps; divide adds one multiply. Configuration writes take effect at once; the
// user must make them only while busy is low, as the block itself does not
// enforce this.
module gf2m_field_alu import gfalu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gfalu_in_t         in_i,
  output logic              result_valid_o,
  output gfalu_out_t        result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ELEM_W-1:0] cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_FIN_W     = 8'b0000_0010,
    S_POW_STEP  = 8'b0000_0100,
    S_POW_MUL_W = 8'b0000_1000,
    S_POW_SQR_W = 8'b0001_0000,
    S_INV_DEG   = 8'b0010_0000,
    S_INV_RED   = 8'b0100_0000,
    S_INV_W     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [DEG_W-1:0]  field_degree_q;
  logic [ELEM_W-1:0] reduction_poly_q;

  logic [DEG_W-1:0]  m_eff, m_less;
  logic [MOD_W-1:0]  modulus;
  field_t            field;

  op_e               op_q, op_d;
  logic [ELEM_W-1:0] a_q, a_d;
  logic [EXP_W-1:0]  e_q, e_d;
  logic [ELEM_W-1:0] pacc_q, pacc_d, pbase_q, pbase_d;
  logic [MOD_W-1:0]  u_q, u_d, v_q, v_d;
  logic [ELEM_W-1:0] g1_q, g1_d, g2_q, g2_d;
  logic [DEG_W-1:0]  du_q, du_d, dv_q, dv_d;
  logic              res_valid_q, res_valid_d;
  gfalu_out_t        res_q, res_d;

  logic [ELEM_W-1:0] in_a, in_b, div_src;
  logic [MOD_W-1:0]  u_sw, v_sw;
  logic [ELEM_W-1:0] g1_sw, g2_sw;
  logic [DEG_W-1:0]  jsh;
  logic              accept;

  logic              mul_start, mul_done;
  logic [ELEM_W-1:0] mul_a, mul_b, mul_prod;

  function automatic logic [DEG_W-1:0] poly_deg(input logic [MOD_W-1:0] x);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int k = 0; k < MOD_W; k++) begin
      if (x[k]) begin
        d = DEG_W'(k);
      end
    end
    return d;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_degree_q   <= RESET_DEGREE;
      reduction_poly_q <= RESET_POLY;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DEGREE) begin
        field_degree_q <= cfg_data_i[DEG_W-1:0];
      end else begin
        reduction_poly_q <= cfg_data_i;
      end
    end
  end

  // effective field description
  always_comb begin
    if (field_degree_q == '0) begin
      m_eff = DEG_W'(1);
    end else if (field_degree_q > DEG_W'(MAX_DEGREE)) begin
      m_eff = DEG_W'(MAX_DEGREE);
    end else begin
      m_eff = field_degree_q;
    end
    m_less        = m_eff - DEG_W'(1);
    field.mask    = ELEM_W'((MOD_W'(1) << m_eff) - MOD_W'(1));
    field.poly    = reduction_poly_q & field.mask;
    field.top_idx = m_less[TOP_W-1:0];
    modulus       = (MOD_W'(1) << m_eff) | MOD_W'(field.poly);
  end

  assign accept  = start && (state_q == S_IDLE);
  assign in_a    = in_i.operand_a & field.mask;
  assign in_b    = in_i.operand_b & field.mask;
  assign div_src = (op_e'(in_i.operation) == OP_INV) ? in_a : in_b;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    e_d         = e_q;
    pacc_d      = pacc_q;
    pbase_d     = pbase_q;
    u_d         = u_q;
    v_d         = v_q;
    g1_d        = g1_q;
    g2_d        = g2_q;
    du_d        = du_q;
    dv_d        = dv_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    u_sw        = u_q;
    v_sw        = v_q;
    g1_sw       = g1_q;
    g2_sw       = g2_q;
    jsh         = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(in_i.operation);
          a_d  = in_a;
          case (op_e'(in_i.operation))
            OP_ADD: begin
              res_valid_d    = 1'b1;
              res_d.result   = in_a ^ in_b;
              res_d.status   = ST_OK;
            end
            OP_MUL: begin
              mul_start = 1'b1;
              mul_a     = in_a;
              mul_b     = in_b;
              state_d   = S_FIN_W;
            end
            OP_POW: begin
              pacc_d  = ELEM_W'(1);
              pbase_d = in_a;
              e_d     = in_i.exponent;
              state_d = S_POW_STEP;
            end
            OP_INV, OP_DIV: begin
              if (div_src == '0) begin
                res_valid_d  = 1'b1;
                res_d.result = '0;
                res_d.status = ST_ZERO;
              end else begin
                u_d     = MOD_W'(div_src);
                v_d     = modulus;
                g1_d    = ELEM_W'(1);
                g2_d    = '0;
                state_d = S_INV_DEG;
              end
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.result = '0;
              res_d.status = ST_OK;
            end
          endcase
        end
      end
      S_FIN_W: begin
        if (mul_done) begin
          res_valid_d  = 1'b1;
          res_d.result = mul_prod;
          res_d.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_POW_STEP: begin
        if (e_q == '0) begin
          res_valid_d  = 1'b1;
          res_d.result = pacc_q;
          res_d.status = ST_OK;
          state_d      = S_IDLE;
        end else if (e_q[0]) begin
          mul_start = 1'b1;
          mul_a     = pacc_q;
          mul_b     = pbase_q;
          state_d   = S_POW_MUL_W;
        end else begin
          mul_start = 1'b1;
          mul_a     = pbase_q;
          mul_b     = pbase_q;
          state_d   = S_POW_SQR_W;
        end
      end
      S_POW_MUL_W: begin
        if (mul_done) begin
          pacc_d    = mul_prod;
          mul_start = 1'b1;
          mul_a     = pbase_q;
          mul_b     = pbase_q;
          state_d   = S_POW_SQR_W;
        end
      end
      S_POW_SQR_W: begin
        if (mul_done) begin
          pbase_d = mul_prod;
          e_d     = e_q >> 1;
          state_d = S_POW_STEP;
        end
      end
      S_INV_DEG: begin
        du_d = poly_deg(u_q);
        dv_d = poly_deg(v_q);
        if (u_q == MOD_W'(1)) begin
          if (op_q == OP_INV) begin
            res_valid_d  = 1'b1;
            res_d.result = g1_q;
            res_d.status = ST_OK;
            state_d      = S_IDLE;
          end else begin
            mul_start = 1'b1;
            mul_a     = a_q;
            mul_b     = g1_q;
            state_d   = S_FIN_W;
          end
        end else if (u_q == '0) begin
          res_valid_d  = 1'b1;
          res_d.result = '0;
          res_d.status = ST_NONINV;
          state_d      = S_IDLE;
        end else begin
          state_d = S_INV_RED;
        end
      end
      S_INV_RED: begin
        if (du_q < dv_q) begin
          u_sw  = v_q;
          v_sw  = u_q;
          g1_sw = g2_q;
          g2_sw = g1_q;
          jsh   = dv_q - du_q;
        end else begin
          jsh   = du_q - dv_q;
        end
        u_d       = u_sw ^ (v_sw << jsh);
        v_d       = v_sw;
        g1_d      = g1_sw;
        g2_d      = g2_sw;
        mul_start = 1'b1;
        mul_a     = g2_sw;
        mul_b     = ELEM_W'(1) << jsh[TOP_W-1:0];
        state_d   = S_INV_W;
      end
      S_INV_W: begin
        if (mul_done) begin
          g1_d    = g1_q ^ mul_prod;
          state_d = S_INV_DEG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    e_q     <= e_d;
    pacc_q  <= pacc_d;
    pbase_q <= pbase_d;
    u_q     <= u_d;
    v_q     <= v_d;
    g1_q    <= g1_d;
    g2_q    <= g2_d;
    du_q    <= du_d;
    dv_q    <= dv_d;
    res_q   <= res_d;
  end

  gfalu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .field_i (field),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.status == ST_OK) || (res_q.result == '0)))
    else $error("error status with nonzero result");
  a_result_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((res_q.result & ~field.mask) == '0))
    else $error("result exceeds field degree");
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past((state_q != S_IDLE) || start))
    else $error("result issued without an item");
  a_reduce_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INV_RED) |-> ((u_q != '0) && (u_q != MOD_W'(1)) && (v_q != '0)))
    else $error("euclid step on finished operands");
`endif

endmodule
